// ===== sv/tsh_pkg.sv =====
package tsh_pkg;

  localparam int HASH_KINDS  = 5;
  localparam int KIND_W      = 3;
  localparam int CH_W        = 8;
  localparam int ADDR_W      = KIND_W + CH_W;
  localparam int TABLE_WORDS = HASH_KINDS * (2 ** CH_W);
  localparam int WORD_W      = 32;
  localparam int HALF_W      = WORD_W / 2;

  // generator: seed = (seed * 125 + 3) mod 0x2AAAAB
  localparam int          SEED_W   = 22;
  localparam int          PROD_W   = 29;
  localparam int          QUOT_W   = 8;
  localparam int          LCG_MUL  = 125;
  localparam int          LCG_ADD  = 3;
  localparam logic [SEED_W-1:0] SEED_INIT = 22'h100001;
  localparam logic [SEED_W-1:0] SEED_MOD  = 22'h2AAAAB;
  // 3 * SEED_MOD == 2**23 + 1, so (3 * x) >> 23 is the quotient or one above it
  localparam int          QUOT_SHIFT = 23;

  localparam logic [WORD_W-1:0] ACC_ONE_INIT = 32'h7FED7FED;
  localparam logic [WORD_W-1:0] ACC_TWO_INIT = 32'hEEEEEEEE;
  localparam logic [WORD_W-1:0] ACC_TWO_ADD  = 32'd3;
  localparam int                ACC_TWO_SHL  = 5;

  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CH_W-1:0] CH_CASE_OFFSET = 8'h20;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    GEN_STEP,
    GEN_REDUCE,
    GEN_DONE
  } tsh_gen_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } tsh_wr_t;

  typedef struct packed {
    logic              last;
    logic [ADDR_W-1:0] addr;
  } tsh_item_t;

endpackage

// ===== sv/table_string_hash_core.sv =====
// one-way string hash over a generated 1280-word mixing table
//
// input channel: push/full carry one string byte per word, with its hash kind
// (0..4, larger values use kind 4) and a flag marking the last byte of the string.
// result channel: empty/pop; one 32-bit hash is queued for each last byte.
//
// after reset the table is filled by a linear congruential generator whose steps
// each pass through GEN_STEP and GEN_REDUCE, two steps per entry, and full stays high
// until the whole table is written, so no byte is taken before the fill ends.
//
// after the fill one byte is accepted per cycle while the byte queue has room; the table
// read and the running sum update are one stage each, and the hash of a string passes
// through the byte queue, the table read register and the mix stage to out_hash_value.
// a 4-entry byte queue decouples the input from the table read, and a 4-entry
// result queue holds finished hashes: while pop stays low, bytes keep flowing
// until the result queue fills, then full rises once the byte queue is full.
module table_string_hash_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [tsh_pkg::CH_W-1:0]   in_byte_value,
  input  logic [tsh_pkg::KIND_W-1:0] in_hash_kind,
  input  logic                       in_last_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [tsh_pkg::WORD_W-1:0] out_hash_value
);

  tsh_pkg::tsh_wr_t   wr;
  logic               table_ready;
  logic               q_valid;
  logic               q_pop;
  tsh_pkg::tsh_item_t q_item;

  tsh_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .ready (table_ready)
  );

  tsh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .table_ready (table_ready),
    .push        (push),
    .full        (full),
    .byte_value  (in_byte_value),
    .hash_kind   (in_hash_kind),
    .last_byte   (in_last_byte),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  tsh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .hash_value (out_hash_value)
  );

endmodule

// ===== sv/tsh_gen.sv =====
module tsh_gen (
  input  logic             clk,
  input  logic             rst_n,
  output tsh_pkg::tsh_wr_t wr,
  output logic             ready
);

  tsh_pkg::tsh_gen_state_t state_r, state_nxt;

  logic [tsh_pkg::SEED_W-1:0] seed_r;
  logic [tsh_pkg::PROD_W-1:0] prod_r;
  logic [tsh_pkg::QUOT_W-1:0] quot_r;
  logic                       half_r;
  logic [tsh_pkg::HALF_W-1:0] hi_r;
  logic [tsh_pkg::KIND_W-1:0] col_r;
  logic [tsh_pkg::CH_W-1:0]   row_r;

  logic [tsh_pkg::PROD_W-1:0] prod_w;
  logic [tsh_pkg::PROD_W+1:0] trip_w;
  logic [tsh_pkg::PROD_W:0]   sub_w;
  logic [tsh_pkg::PROD_W:0]   fix_w;
  logic [tsh_pkg::SEED_W-1:0] rem_w;
  logic                       last_word_w;
  logic                       adv_w;

  assign prod_w = tsh_pkg::PROD_W'(seed_r) * tsh_pkg::PROD_W'(tsh_pkg::LCG_MUL)
                + tsh_pkg::PROD_W'(tsh_pkg::LCG_ADD);
  assign trip_w = {2'b00, prod_w} + {1'b0, prod_w, 1'b0};

  // estimated quotient is exact or one too large: add the modulus back once
  assign sub_w = {1'b0, prod_r}
               - ((tsh_pkg::PROD_W + 1)'(quot_r) * (tsh_pkg::PROD_W + 1)'(tsh_pkg::SEED_MOD));
  assign fix_w = sub_w + (tsh_pkg::PROD_W + 1)'(tsh_pkg::SEED_MOD);
  assign rem_w = sub_w[tsh_pkg::PROD_W] ? fix_w[tsh_pkg::SEED_W-1:0]
                                         : sub_w[tsh_pkg::SEED_W-1:0];

  assign last_word_w = (row_r == {tsh_pkg::CH_W{1'b1}})
                    && (col_r == tsh_pkg::KIND_W'(tsh_pkg::HASH_KINDS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsh_pkg::GEN_STEP: begin
        state_nxt = tsh_pkg::GEN_REDUCE;
      end
      tsh_pkg::GEN_REDUCE: begin
        state_nxt = (half_r && last_word_w) ? tsh_pkg::GEN_DONE : tsh_pkg::GEN_STEP;
      end
      tsh_pkg::GEN_DONE: begin
        state_nxt = tsh_pkg::GEN_DONE;
      end
      default: begin
        state_nxt = tsh_pkg::GEN_STEP;
      end
    endcase
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = {col_r, row_r};
    wr.data = {hi_r, rem_w[tsh_pkg::HALF_W-1:0]};
    ready   = 1'b0;
    adv_w   = 1'b0;
    case (state_r)
      tsh_pkg::GEN_STEP: begin
        adv_w = 1'b0;
      end
      tsh_pkg::GEN_REDUCE: begin
        adv_w = 1'b1;
        wr.en = half_r;
      end
      tsh_pkg::GEN_DONE: begin
        ready = 1'b1;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsh_pkg::GEN_STEP;
      seed_r  <= tsh_pkg::SEED_INIT;
      half_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (adv_w) begin
        seed_r <= rem_w;
        half_r <= ~half_r;
        // fill order walks the kinds first, then the byte codes
        if (half_r) begin
          if (col_r == tsh_pkg::KIND_W'(tsh_pkg::HASH_KINDS - 1)) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tsh_pkg::GEN_STEP) begin
      prod_r <= prod_w;
      quot_r <= trip_w[tsh_pkg::QUOT_SHIFT +: tsh_pkg::QUOT_W];
    end
    if (adv_w && !half_r) begin
      hi_r <= rem_w[tsh_pkg::HALF_W-1:0];
    end
  end

  a_seed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seed_r < tsh_pkg::SEED_MOD)
    else $error("generator seed not reduced");

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ready |-> !wr.en)
    else $error("table write after fill complete");

endmodule

// ===== sv/tsh_front.sv =====
module tsh_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       table_ready,
  input  logic                       push,
  output logic                       full,
  input  logic [tsh_pkg::CH_W-1:0]   byte_value,
  input  logic [tsh_pkg::KIND_W-1:0] hash_kind,
  input  logic                       last_byte,
  output logic                       q_valid,
  output tsh_pkg::tsh_item_t         q_item,
  input  logic                       q_pop
);

  tsh_pkg::tsh_item_t           fq_mem_r [tsh_pkg::FQ_DEPTH];
  logic [tsh_pkg::FQ_PTR_W-1:0] wr_ptr_r;
  logic [tsh_pkg::FQ_PTR_W-1:0] rd_ptr_r;
  logic [tsh_pkg::FQ_CNT_W-1:0] cnt_r;

  logic [tsh_pkg::CH_W-1:0]   ch_w;
  logic [tsh_pkg::KIND_W-1:0] kind_w;
  tsh_pkg::tsh_item_t         item_w;
  logic                       push_w;

  // fold a-z to upper case, clamp out-of-range kinds to the last section
  assign ch_w = (byte_value >= tsh_pkg::CH_LOWER_A && byte_value <= tsh_pkg::CH_LOWER_Z)
              ? byte_value - tsh_pkg::CH_CASE_OFFSET : byte_value;
  assign kind_w = (hash_kind >= tsh_pkg::KIND_W'(tsh_pkg::HASH_KINDS))
                ? tsh_pkg::KIND_W'(tsh_pkg::HASH_KINDS - 1) : hash_kind;
  assign item_w.last = last_byte;
  assign item_w.addr = {kind_w, ch_w};

  assign full    = !table_ready || (cnt_r == tsh_pkg::FQ_CNT_W'(tsh_pkg::FQ_DEPTH));
  assign push_w  = push && !full;
  assign q_valid = (cnt_r != '0);
  assign q_item  = fq_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_w) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + tsh_pkg::FQ_CNT_W'(push_w) - tsh_pkg::FQ_CNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      fq_mem_r[wr_ptr_r] <= item_w;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("byte queue popped while empty");

endmodule

// ===== sv/tsh_back.sv =====
module tsh_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsh_pkg::tsh_wr_t           wr,
  input  logic                       q_valid,
  input  tsh_pkg::tsh_item_t         q_item,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [tsh_pkg::WORD_W-1:0] hash_value
);

  logic [tsh_pkg::WORD_W-1:0] table_mem_r [tsh_pkg::TABLE_WORDS];
  logic [tsh_pkg::WORD_W-1:0] rd_data_r;
  logic                       s2_valid_r;
  logic                       s2_last_r;
  logic [tsh_pkg::CH_W-1:0]   s2_ch_r;
  logic [tsh_pkg::WORD_W-1:0] acc_one_r;
  logic [tsh_pkg::WORD_W-1:0] acc_two_r;

  logic [tsh_pkg::WORD_W-1:0]   oq_mem_r [tsh_pkg::OQ_DEPTH];
  logic [tsh_pkg::OQ_PTR_W-1:0] oq_wr_ptr_r;
  logic [tsh_pkg::OQ_PTR_W-1:0] oq_rd_ptr_r;
  logic [tsh_pkg::OQ_CNT_W-1:0] oq_cnt_r;

  logic [tsh_pkg::OQ_CNT_W:0] credit_w;
  logic                       push_w;
  logic                       pop_w;
  logic [tsh_pkg::WORD_W-1:0] sum_w;
  logic [tsh_pkg::WORD_W-1:0] acc_one_nxt;
  logic [tsh_pkg::WORD_W-1:0] part_w;
  logic [tsh_pkg::WORD_W-1:0] acc_two_nxt;

  // count a word still in the mix stage against the result queue space
  assign credit_w = {1'b0, oq_cnt_r} + (tsh_pkg::OQ_CNT_W + 1)'(s2_valid_r && s2_last_r);
  assign q_pop    = q_valid && (credit_w < (tsh_pkg::OQ_CNT_W + 1)'(tsh_pkg::OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      table_mem_r[wr.addr] <= wr.data;
    end
    if (q_pop) begin
      rd_data_r <= table_mem_r[q_item.addr];
      s2_last_r <= q_item.last;
      s2_ch_r   <= q_item.addr[tsh_pkg::CH_W-1:0];
    end
  end

  // acc_two * 33 + ch + 3 does not wait on the new acc_one
  assign sum_w       = acc_one_r + acc_two_r;
  assign acc_one_nxt = rd_data_r ^ sum_w;
  assign part_w      = acc_two_r + (acc_two_r << tsh_pkg::ACC_TWO_SHL)
                     + tsh_pkg::WORD_W'(s2_ch_r) + tsh_pkg::ACC_TWO_ADD;
  assign acc_two_nxt = acc_one_nxt + part_w;

  assign push_w     = s2_valid_r && s2_last_r;
  assign empty      = (oq_cnt_r == '0);
  assign pop_w      = pop && !empty;
  assign hash_value = oq_mem_r[oq_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      acc_one_r   <= tsh_pkg::ACC_ONE_INIT;
      acc_two_r   <= tsh_pkg::ACC_TWO_INIT;
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      s2_valid_r <= q_pop;
      if (s2_valid_r) begin
        if (s2_last_r) begin
          acc_one_r <= tsh_pkg::ACC_ONE_INIT;
          acc_two_r <= tsh_pkg::ACC_TWO_INIT;
        end else begin
          acc_one_r <= acc_one_nxt;
          acc_two_r <= acc_two_nxt;
        end
      end
      if (push_w) begin
        oq_wr_ptr_r <= oq_wr_ptr_r + 1'b1;
      end
      if (pop_w) begin
        oq_rd_ptr_r <= oq_rd_ptr_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_r + tsh_pkg::OQ_CNT_W'(push_w) - tsh_pkg::OQ_CNT_W'(pop_w);
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) begin
      oq_mem_r[oq_wr_ptr_r] <= acc_one_nxt;
    end
  end

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_w |-> (oq_cnt_r < tsh_pkg::OQ_CNT_W'(tsh_pkg::OQ_DEPTH)))
    else $error("result queue overflow");

  a_mix_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s2_valid_r)
    else $error("issued word lost before mix stage");

endmodule

// ===== tb/sv/tb_table_string_hash_core.sv =====
module tb_table_string_hash_core;

  localparam int QUIET_LIMIT = 20000;
  localparam int RANDOM_BYTES = 900;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 60;

  typedef struct packed {
    logic [tsh_pkg::CH_W-1:0]   ch;
    logic [tsh_pkg::KIND_W-1:0] kind;
    logic                       is_last;
  } str_byte_t;

  // single-byte strings at the field extremes, case folding edges, kinds past the
  // last section, then multi-byte strings, two of them switching kind mid-string
  localparam str_byte_t DIRECTED_BYTES [22] = '{
    '{ch: 8'h00, kind: 3'd0, is_last: 1'b1},
    '{ch: 8'hFF, kind: 3'd4, is_last: 1'b1},
    '{ch: 8'h61, kind: 3'd1, is_last: 1'b1},
    '{ch: 8'h41, kind: 3'd1, is_last: 1'b1},
    '{ch: 8'h7A, kind: 3'd2, is_last: 1'b1},
    '{ch: 8'h5A, kind: 3'd2, is_last: 1'b1},
    '{ch: 8'h60, kind: 3'd3, is_last: 1'b1},
    '{ch: 8'h7B, kind: 3'd3, is_last: 1'b1},
    '{ch: 8'h40, kind: 3'd0, is_last: 1'b1},
    '{ch: 8'h55, kind: 3'd5, is_last: 1'b1},
    '{ch: 8'h55, kind: 3'd6, is_last: 1'b1},
    '{ch: 8'h55, kind: 3'd7, is_last: 1'b1},
    '{ch: 8'h55, kind: 3'd4, is_last: 1'b1},
    '{ch: 8'h68, kind: 3'd2, is_last: 1'b0},
    '{ch: 8'h65, kind: 3'd2, is_last: 1'b0},
    '{ch: 8'h6C, kind: 3'd2, is_last: 1'b0},
    '{ch: 8'h6C, kind: 3'd2, is_last: 1'b0},
    '{ch: 8'h6F, kind: 3'd2, is_last: 1'b1},
    '{ch: 8'h41, kind: 3'd0, is_last: 1'b0},
    '{ch: 8'h62, kind: 3'd3, is_last: 1'b1},
    '{ch: 8'h80, kind: 3'd1, is_last: 1'b0},
    '{ch: 8'h7F, kind: 3'd7, is_last: 1'b1}
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         push = 1'b0;
  logic                         full;
  logic [tsh_pkg::CH_W-1:0]     in_byte_value = '0;
  logic [tsh_pkg::KIND_W-1:0]   in_hash_kind = '0;
  logic                         in_last_byte = 1'b0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [tsh_pkg::WORD_W-1:0]   out_hash_value;

  logic [tsh_pkg::WORD_W-1:0] mix_words [tsh_pkg::TABLE_WORDS];
  logic [tsh_pkg::WORD_W-1:0] run_one;
  logic [tsh_pkg::WORD_W-1:0] run_two;
  logic [tsh_pkg::WORD_W-1:0] hash_due [$];

  logic steady = 1'b0;
  int   faults = 0;
  int   bytes_sent = 0;
  int   strings_sent = 0;
  int   hashes_seen = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   quiet_cycles = 0;

  table_string_hash_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte_value  (in_byte_value),
    .in_hash_kind   (in_hash_kind),
    .in_last_byte   (in_last_byte),
    .empty          (empty),
    .pop            (pop),
    .out_hash_value (out_hash_value)
  );

  always #6 clk = ~clk;

  function automatic logic [tsh_pkg::SEED_W-1:0] seed_step(logic [tsh_pkg::SEED_W-1:0] s);
    longint unsigned t;
    t = (longint'(s) * tsh_pkg::LCG_MUL + tsh_pkg::LCG_ADD) % longint'(tsh_pkg::SEED_MOD);
    return t[tsh_pkg::SEED_W-1:0];
  endfunction

  // two generator steps per entry, entries dealt round-robin over the sections
  function automatic void build_mix_words();
    logic [tsh_pkg::SEED_W-1:0] seed;
    logic [tsh_pkg::HALF_W-1:0] hi;
    int                         addr;
    seed = tsh_pkg::SEED_INIT;
    for (int n = 0; n < tsh_pkg::TABLE_WORDS; n++) begin
      seed = seed_step(seed);
      hi = seed[tsh_pkg::HALF_W-1:0];
      seed = seed_step(seed);
      addr = n / tsh_pkg::HASH_KINDS + (n % tsh_pkg::HASH_KINDS) * 256;
      mix_words[tsh_pkg::ADDR_W'(addr)] = {hi, seed[tsh_pkg::HALF_W-1:0]};
    end
  endfunction

  function automatic void absorb_byte(logic [tsh_pkg::CH_W-1:0] b,
                                      logic [tsh_pkg::KIND_W-1:0] k, logic is_last);
    logic [tsh_pkg::CH_W-1:0] ch;
    int                       sect;
    ch = b;
    if (b >= tsh_pkg::CH_LOWER_A && b <= tsh_pkg::CH_LOWER_Z) ch = b - tsh_pkg::CH_CASE_OFFSET;
    sect = (k >= tsh_pkg::HASH_KINDS) ? tsh_pkg::HASH_KINDS - 1 : int'(k);
    run_one = mix_words[tsh_pkg::ADDR_W'(sect * 256 + int'(ch))] ^ (run_one + run_two);
    run_two = tsh_pkg::WORD_W'(ch) + run_one + run_two
            + (run_two << tsh_pkg::ACC_TWO_SHL) + tsh_pkg::ACC_TWO_ADD;
    if (is_last) begin
      hash_due.push_back(run_one);
      run_one = tsh_pkg::ACC_ONE_INIT;
      run_two = tsh_pkg::ACC_TWO_INIT;
      strings_sent++;
    end
  endfunction

  function automatic void report_fault(string what, logic [tsh_pkg::WORD_W-1:0] want,
                                       logic [tsh_pkg::WORD_W-1:0] got);
    if (faults < 10)
      $display("[%0t] %s: expected %08h got %08h", $time, what, want, got);
    faults++;
  endfunction

  task automatic offer_byte(input logic [tsh_pkg::CH_W-1:0] b,
                            input logic [tsh_pkg::KIND_W-1:0] k, input logic is_last);
    while (!steady && $urandom_range(0, 99) < 38) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte_value <= b;
    in_hash_kind <= k;
    in_last_byte <= is_last;
    @(posedge clk);
    while (full) @(posedge clk);
    absorb_byte(b, k, is_last);
    bytes_sent++;
  endtask

  // hash side: check each popped word, pick the next pop, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (hash_due.size() == 0) begin
          report_fault("hash with nothing pending", '0, out_hash_value);
        end else begin
          if (out_hash_value !== hash_due[0])
            report_fault("wrong hash", hash_due[0], out_hash_value);
          void'(hash_due.pop_front());
        end
        hashes_seen <= hashes_seen + 1;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (!hold_done && hashes_seen == HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // counts cycles with no word moving on either side; covers the table fill
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("table_string_hash_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int                         len;
    int                         r;
    logic [tsh_pkg::KIND_W-1:0] kind;
    logic [tsh_pkg::CH_W-1:0]   b;

    build_mix_words();
    run_one = tsh_pkg::ACC_ONE_INIT;
    run_two = tsh_pkg::ACC_TWO_INIT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_BYTES[i])
      offer_byte(DIRECTED_BYTES[i].ch, DIRECTED_BYTES[i].kind, DIRECTED_BYTES[i].is_last);

    while (bytes_sent < $size(DIRECTED_BYTES) + RANDOM_BYTES) begin
      steady = (bytes_sent >= 300 && bytes_sent < 450);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      if ($urandom_range(0, 99) < 80)
        kind = tsh_pkg::KIND_W'($urandom_range(0, 4));
      else
        kind = tsh_pkg::KIND_W'($urandom_range(0, 7));
      for (int i = 0; i < len; i++) begin
        // occasionally switch section inside a string
        if ($urandom_range(0, 99) < 10) kind = tsh_pkg::KIND_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 25)
          b = tsh_pkg::CH_W'(8'h41 + $urandom_range(0, 25));
        else if (r < 50)
          b = tsh_pkg::CH_W'(tsh_pkg::CH_LOWER_A + $urandom_range(0, 25));
        else
          b = tsh_pkg::CH_W'($urandom_range(0, 255));
        offer_byte(b, kind, i == len - 1);
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    while (hash_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d string bytes in %0d strings over hash kinds 0-7, with case folding,",
             bytes_sent, strings_sent);
    $display("kind switches inside strings and a %0d-cycle pop hold-off; %0d faults",
             HOLD_CYCLES, faults);
    if (faults == 0) begin
      $display("table_string_hash_core: match");
    end else begin
      $display("table_string_hash_core: mismatch");
    end
    $finish;
  end

endmodule
